### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/i2cms_pkg.sv
// shared types and constants of the i2c master bit sequencer
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

    localparam int unsigned TICK_W = 16;
    localparam int unsigned TRY_W  = 4;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned BIT_W  = 4;

    localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd1000;
    localparam logic [TRY_W-1:0]  ACK_TRIES_RST   = 4'd3;
    localparam logic [BIT_W-1:0]  BITS_PER_BYTE   = 4'd8;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 16;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_START = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ACK   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NACK  = 3'd5;

    // configuration register indexes
    localparam logic CFG_PHASE_TICKS = 1'b0;
    localparam logic CFG_ACK_TRIES   = 1'b1;

    typedef enum logic [11:0] {
        PH_IDLE  = 12'b0000_0000_0001,
        PH_SEQ0  = 12'b0000_0000_0010,
        PH_SEQ1  = 12'b0000_0000_0100,
        PH_SEQ2  = 12'b0000_0000_1000,
        PH_SEQ3  = 12'b0000_0001_0000,
        PH_WHI   = 12'b0000_0010_0000,
        PH_WLO   = 12'b0000_0100_0000,
        PH_WNX   = 12'b0000_1000_0000,
        PH_WSAMP = 12'b0001_0000_0000,
        PH_WFIN  = 12'b0010_0000_0000,
        PH_RHI   = 12'b0100_0000_0000,
        PH_RLO   = 12'b1000_0000_0000
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [KIND_W-1:0]   cmd;
        logic [BIT_W-1:0]    bit_idx;
        logic [BYTE_W-1:0]   shift;
        logic [TICK_W-1:0]   tick;
        logic [TRY_W-1:0]    tries;
        logic                scl;
        logic                sda;
        logic                drive;
        logic [BYTE_W-1:0]   rx;
        logic                ack;
    } t_state;

    localparam t_state STATE_RST = '{
        phase:   PH_IDLE,
        cmd:     '0,
        bit_idx: '0,
        shift:   '0,
        tick:    '0,
        tries:   '0,
        scl:     1'b0,
        sda:     1'b0,
        drive:   1'b1,
        rx:      '0,
        ack:     1'b0
    };

endpackage

`default_nettype wire

### rtl/i2c_master_bit_sequencer_core.sv
// top level of the tick-driven i2c master bit sequencer
`timescale 1ns / 1ps
`default_nettype none

// Each input transaction is one timebase tick carrying an optional command
// (start, stop, write byte, read byte, ack, nack) and the sampled SDA level;
// each tick yields exactly one output transaction with the pin levels, busy
// and done flags, the last read byte and the last acknowledge result. A tick
// is taken every clock cycle while the input is ready: the sequencer state
// advances in one pass of next-state logic, and the result is registered in
// an output register. Input is ready whenever that register is empty or being
// drained, so with the output side ready the block sustains one tick per cycle.
// Commands offered while a sequence runs, and kinds 6 and 7, are ignored.
// The configuration port writes phase_ticks (index 0) and ack_tries (index 1).

module i2c_master_bit_sequencer_core (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    s_axis_tvalid,
    output logic                                   s_axis_tready,
    // cmd_valid[0], kind[3:1], tx_byte[11:4], sda_in[12], zero fill
    input  wire  [i2cms_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire                                    m_axis_tready,
    // scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
    // rx_byte[12:5], ack_ok[13], zero fill
    output logic [i2cms_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  wire                                    i_cfg_we,
    input  wire                                    i_cfg_addr,
    input  wire  [i2cms_pkg::TICK_W-1:0]           i_cfg_wdata
);

    i2cms_pkg::t_state                   r_state;
    i2cms_pkg::t_state                   n_state;
    logic                                n_done;
    logic [i2cms_pkg::TICK_W-1:0]        r_phase_ticks;
    logic [i2cms_pkg::TRY_W-1:0]         r_ack_tries;
    logic                                r_out_valid;
    logic [i2cms_pkg::OUT_DATA_W-1:0]    r_out_data;
    logic [i2cms_pkg::OUT_DATA_W-1:0]    n_out_data;
    logic                                in_take;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    i2cms_step u_step (
        .i_state       (r_state),
        .i_cmd_valid   (s_axis_tdata[0]),
        .i_kind        (s_axis_tdata[3:1]),
        .i_tx_byte     (s_axis_tdata[11:4]),
        .i_sda_in      (s_axis_tdata[12]),
        .i_phase_ticks (r_phase_ticks),
        .i_ack_tries   (r_ack_tries),
        .o_state       (n_state),
        .o_done        (n_done)
    );

    assign n_out_data = {2'b00,
                         n_state.ack,
                         n_state.rx,
                         n_done,
                         (n_state.phase != i2cms_pkg::PH_IDLE),
                         n_state.drive,
                         n_state.drive & n_state.sda,
                         n_state.scl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cms_pkg::PHASE_TICKS_RST;
            r_ack_tries   <= i2cms_pkg::ACK_TRIES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                i2cms_pkg::CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_wdata;
                i2cms_pkg::CFG_ACK_TRIES:   r_ack_tries   <= i_cfg_wdata[i2cms_pkg::TRY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= i2cms_pkg::STATE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

### rtl/i2cms_step.sv
// next-state logic for one timebase tick of the sequencer
`timescale 1ns / 1ps
`default_nettype none

module i2cms_step (
    input  var i2cms_pkg::t_state                   i_state,
    input  wire                                     i_cmd_valid,
    input  wire  [i2cms_pkg::KIND_W-1:0]            i_kind,
    input  wire  [i2cms_pkg::BYTE_W-1:0]            i_tx_byte,
    input  wire                                     i_sda_in,
    input  wire  [i2cms_pkg::TICK_W-1:0]            i_phase_ticks,
    input  wire  [i2cms_pkg::TRY_W-1:0]             i_ack_tries,
    output i2cms_pkg::t_state                       o_state,
    output logic                                    o_done
);

    always_comb begin
        logic [i2cms_pkg::TICK_W:0]   tick_inc;
        logic [i2cms_pkg::TICK_W-1:0] lim;
        logic [i2cms_pkg::BIT_W-1:0]  bit_inc;
        logic [i2cms_pkg::TRY_W-1:0]  try_inc;
        logic [i2cms_pkg::BYTE_W-1:0] shift_w;
        logic                         two_point;

        o_state   = i_state;
        o_done    = 1'b0;
        tick_inc  = {1'b0, i_state.tick} + 17'd1;
        lim       = (i_phase_ticks == '0) ? 16'd1 : i_phase_ticks;
        bit_inc   = i_state.bit_idx + 4'd1;
        try_inc   = i_state.tries + 4'd1;
        shift_w   = {i_state.shift[i2cms_pkg::BYTE_W-2:0], 1'b0};
        two_point = (i_state.cmd == i2cms_pkg::KIND_ACK)
                 || (i_state.cmd == i2cms_pkg::KIND_NACK);

        if (i_state.phase == i2cms_pkg::PH_IDLE) begin
            if (i_cmd_valid && (i_kind <= i2cms_pkg::KIND_NACK)) begin
                o_state.cmd     = i_kind;
                o_state.tick    = '0;
                o_state.bit_idx = '0;
                o_state.tries   = '0;
                if (i_kind == i2cms_pkg::KIND_WRITE) begin
                    o_state.shift = i_tx_byte;
                    o_state.drive = 1'b1;
                    o_state.sda   = i_tx_byte[i2cms_pkg::BYTE_W-1];
                    o_state.phase = i2cms_pkg::PH_WHI;
                end else if (i_kind == i2cms_pkg::KIND_READ) begin
                    o_state.shift = '0;
                    o_state.drive = 1'b0;
                    o_state.scl   = 1'b1;
                    o_state.phase = i2cms_pkg::PH_RHI;
                end else begin
                    o_state.drive = 1'b1;
                    o_state.scl   = 1'b0;
                    o_state.sda   = (i_kind == i2cms_pkg::KIND_START)
                                 || (i_kind == i2cms_pkg::KIND_NACK);
                    o_state.phase = i2cms_pkg::PH_SEQ0;
                end
            end
        end else if (tick_inc[i2cms_pkg::TICK_W-1:0] < lim) begin
            o_state.tick = tick_inc[i2cms_pkg::TICK_W-1:0];
        end else begin
            o_state.tick = '0;
            case (i_state.phase)
                i2cms_pkg::PH_SEQ0: begin
                    o_state.scl   = 1'b1;
                    o_state.phase = i2cms_pkg::PH_SEQ1;
                end
                i2cms_pkg::PH_SEQ1: begin
                    if (two_point) begin
                        o_state.scl = 1'b0;
                    end else begin
                        o_state.sda = (i_state.cmd == i2cms_pkg::KIND_STOP);
                    end
                    o_state.phase = i2cms_pkg::PH_SEQ2;
                end
                i2cms_pkg::PH_SEQ2: begin
                    if (two_point) begin
                        o_state.phase = i2cms_pkg::PH_IDLE;
                        o_done        = 1'b1;
                    end else begin
                        o_state.scl   = 1'b0;
                        o_state.phase = i2cms_pkg::PH_SEQ3;
                    end
                end
                i2cms_pkg::PH_WHI: begin
                    o_state.scl   = 1'b1;
                    o_state.phase = i2cms_pkg::PH_WLO;
                end
                i2cms_pkg::PH_WLO: begin
                    o_state.scl   = 1'b0;
                    o_state.phase = i2cms_pkg::PH_WNX;
                end
                i2cms_pkg::PH_WNX: begin
                    o_state.shift   = shift_w;
                    o_state.bit_idx = bit_inc;
                    if (bit_inc < i2cms_pkg::BITS_PER_BYTE) begin
                        o_state.sda   = shift_w[i2cms_pkg::BYTE_W-1];
                        o_state.phase = i2cms_pkg::PH_WHI;
                    end else begin
                        o_state.drive = 1'b0;
                        o_state.tries = '0;
                        if (i_ack_tries == '0) begin
                            o_state.scl   = 1'b0;
                            o_state.ack   = 1'b0;
                            o_state.phase = i2cms_pkg::PH_WFIN;
                        end else begin
                            o_state.scl   = 1'b1;
                            o_state.phase = i2cms_pkg::PH_WSAMP;
                        end
                    end
                end
                i2cms_pkg::PH_WSAMP: begin
                    o_state.tries = try_inc;
                    if (!i_sda_in) begin
                        o_state.ack   = 1'b1;
                        o_state.scl   = 1'b0;
                        o_state.phase = i2cms_pkg::PH_WFIN;
                    end else if (try_inc >= i_ack_tries) begin
                        o_state.ack   = 1'b0;
                        o_state.scl   = 1'b0;
                        o_state.phase = i2cms_pkg::PH_WFIN;
                    end
                end
                i2cms_pkg::PH_RHI: begin
                    o_state.shift   = {i_state.shift[i2cms_pkg::BYTE_W-2:0], i_sda_in};
                    o_state.bit_idx = bit_inc;
                    o_state.scl     = 1'b0;
                    o_state.phase   = i2cms_pkg::PH_RLO;
                end
                i2cms_pkg::PH_RLO: begin
                    if (i_state.bit_idx < i2cms_pkg::BITS_PER_BYTE) begin
                        o_state.scl   = 1'b1;
                        o_state.phase = i2cms_pkg::PH_RHI;
                    end else begin
                        o_state.rx    = i_state.shift;
                        o_state.phase = i2cms_pkg::PH_IDLE;
                        o_done        = 1'b1;
                    end
                end
                default: begin
                    // end of stop/start, end of write, and any stray code
                    o_state.phase = i2cms_pkg::PH_IDLE;
                    o_done        = 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/i2cms_checker.sv
// port-level checker for the sequencer core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module i2cms_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  s_axis_tvalid,
    input wire                                  s_axis_tready,
    input wire                                  m_axis_tvalid,
    input wire                                  m_axis_tready,
    input wire [i2cms_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    `ASSERT_CLK(a_out_hold,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "output transaction dropped or changed while stalled")
    `ASSERT_CLK(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready,
        "input not ready with empty output register")
    `ASSERT_CLK(a_done_not_busy, m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3],
        "done reported while still busy")
    `ASSERT_CLK(a_released_sda_low, m_axis_tvalid && !m_axis_tdata[2] |-> !m_axis_tdata[1],
        "sda level set while released")
    `ASSERT_CLK_ALWAYS(a_reset_empty, !i_rst_n |=> !m_axis_tvalid,
        "output valid right after reset")

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
